// File: rtl/core/ftm_pkg.sv
// Shared types and constants of the four-track mixer core.
// No dependencies; every other file of the core imports this package.
package ftm_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int LANE_W       = SAMPLE_W + 1;
  localparam int GAIN_W       = 7;
  localparam int MASK_W       = 4;
  localparam int INPUT_TRACKS = 4;
  localparam int PCT_DIVISOR  = 100;
  localparam int BOOST        = 12;
  localparam int MIX_MAX      = 32767;
  localparam int MIX_MIN      = -32768;
  localparam int GAIN_RESET   = 100;

  // Pipeline depths of the scale unit and of the merge path.
  localparam int SCALE_LAT = 4;
  localparam int MERGE_LAT = SCALE_LAT + 2;
  localparam int MIX_LAT   = SCALE_LAT + MERGE_LAT;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_ENABLE_MASK = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_TRACK_ZERO   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_TRACK_ONE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_TRACK_TWO    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_TRACK_THREE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MASTER_GAIN       = 3'd5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_track_zero;
    logic signed [SAMPLE_W-1:0] sample_track_one;
    logic signed [SAMPLE_W-1:0] sample_track_two;
    logic signed [SAMPLE_W-1:0] sample_track_three;
    logic                       loop_end;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_out;
    logic                       level_valid;
    logic [SAMPLE_W-1:0]        level_peak;
  } result_t;

  // Mixed sample handed from the merge path to the meter.
  typedef struct packed {
    logic                       vld;
    logic                       loop_end;
    logic signed [SAMPLE_W-1:0] mix;
  } mix_beat_t;

endpackage

// File: rtl/core/ftm_if.sv
// Valid/ready channel interfaces for input frames and mixer results.
// Depends on ftm_pkg for the payload types.
interface ftm_frame_if import ftm_pkg::*; ();
  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftm_result_if import ftm_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/four_track_mixer_with_peak_meter_core.sv
// Four-track mixer with windowed peak meter, top level.
// Depends on ftm_pkg, ftm_if, ftm_pct_scale, ftm_merge and ftm_meter.
//
// Frames enter on the frame channel, one signed sample per track plus the
// loop_end mark; one result beat leaves on the result channel for every frame.
// Each track has its own scale lane (gain multiply, reciprocal divide by 100);
// a merge path sums the lanes and applies master gain, boost and clamp, and
// the meter closes a level window after WINDOW_LEN frames or at loop_end.
// Throughput: one frame per cycle. Pipeline: eleven register stages, the
// two four-stage percent scalers in series plus the sum, clamp and output
// registers. The whole pipeline advances as one: when the result beat
// is stalled, frame.ready drops and every stage holds.
// Configuration: write cfg_data to register cfg_index while cfg_write is high;
// 0 track enable mask, 1..4 track gains, 5 master gain; other indexes are
// ignored. Write only while no frame is in flight.
// Reset (synchronous, active high) holds frame.ready low, empties the
// pipeline, restarts the level window and loads mask 0 and all gains 100.
module four_track_mixer_with_peak_meter_core import ftm_pkg::*; #(
  parameter int TRACK_COUNT  = 4,
  parameter int WINDOW_LEN   = 120,
  parameter int LEVEL_STRIDE = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  ftm_frame_if.sink              frame,
  ftm_result_if.source           result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data
);

  localparam int LANES = (TRACK_COUNT < INPUT_TRACKS) ? TRACK_COUNT : INPUT_TRACKS;

  logic [MASK_W-1:0] track_enable_mask;
  logic [GAIN_W-1:0] gain_track [INPUT_TRACKS];
  logic [GAIN_W-1:0] master_gain;

  logic                        adv;
  logic                        out_vld;
  logic [MIX_LAT-1:0]          vld_pipe;
  logic [MIX_LAT-1:0]          end_pipe;
  logic signed [SAMPLE_W-1:0]  samples [INPUT_TRACKS];
  logic [LANES-1:0][LANE_W-1:0] lane_q;
  logic signed [SAMPLE_W-1:0]  mix;
  mix_beat_t                   beat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      track_enable_mask <= '0;
      master_gain       <= GAIN_W'(GAIN_RESET);
      for (int t = 0; t < INPUT_TRACKS; t++) begin
        gain_track[t] <= GAIN_W'(GAIN_RESET);
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TRACK_ENABLE_MASK: track_enable_mask <= cfg_data[MASK_W-1:0];
        REG_GAIN_TRACK_ZERO:   gain_track[0]     <= cfg_data;
        REG_GAIN_TRACK_ONE:    gain_track[1]     <= cfg_data;
        REG_GAIN_TRACK_TWO:    gain_track[2]     <= cfg_data;
        REG_GAIN_TRACK_THREE:  gain_track[3]     <= cfg_data;
        REG_MASTER_GAIN:       master_gain       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance when the output register is empty or being drained
  assign adv          = !out_vld || result.ready;
  assign frame.ready  = adv && !rst;
  assign result.valid = out_vld;

  assign samples[0] = frame.data.sample_track_zero;
  assign samples[1] = frame.data.sample_track_one;
  assign samples[2] = frame.data.sample_track_two;
  assign samples[3] = frame.data.sample_track_three;

  for (genvar t = 0; t < LANES; t++) begin : g_lane
    logic signed [SAMPLE_W-1:0] x;
    logic signed [LANE_W-1:0]   q;

    // a disabled track feeds zero, which scales to zero
    assign x = track_enable_mask[t] ? samples[t] : '0;

    ftm_pct_scale #(.W(SAMPLE_W)) u_scale (
      .clk  (clk),
      .en   (adv),
      .x    (x),
      .gain (gain_track[t]),
      .q    (q)
    );

    assign lane_q[t] = q;
  end

  ftm_merge #(.LANES(LANES)) u_merge (
    .clk         (clk),
    .en          (adv),
    .master_gain (master_gain),
    .lane_q      (lane_q),
    .mix         (mix)
  );

  // Carry beat valid and loop_end alongside the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else if (adv) begin
      vld_pipe <= {vld_pipe[MIX_LAT-2:0], frame.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      end_pipe <= {end_pipe[MIX_LAT-2:0], frame.data.loop_end};
    end
  end

  assign beat.vld      = vld_pipe[MIX_LAT-1];
  assign beat.loop_end = end_pipe[MIX_LAT-1];
  assign beat.mix      = mix;

  ftm_meter #(
    .WINDOW_LEN   (WINDOW_LEN),
    .LEVEL_STRIDE (LEVEL_STRIDE)
  ) u_meter (
    .clk     (clk),
    .rst     (rst),
    .step    (adv),
    .beat    (beat),
    .out_vld (out_vld),
    .res     (result.data)
  );

endmodule

// File: rtl/core/ftm_pct_scale.sv
// Pipelined percent scaler: q = (x * gain) / 100, truncated toward zero.
// Depends on ftm_pkg; used by every track lane and by the master stage.
module ftm_pct_scale import ftm_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x,
  input  logic [GAIN_W-1:0]   gain,
  output logic signed [W:0]   q
);

  // |x * gain| < 2^(W+6), so M magnitude bits; reciprocal error stays below one.
  localparam int M = W + 6;
  localparam logic [W-1:0] RECIP = W'((64'd1 << M) / PCT_DIVISOR);

  logic signed [W+7:0] prod_a;
  logic [M-1:0]        mag_b;
  logic                neg_b;
  logic [M-1:0]        mag_c;
  logic [M+W-1:0]      mk_c;
  logic                neg_c;

  logic signed [W+7:0] gain_s;
  logic [W+7:0]        mag_full;
  logic [W-1:0]        q0;
  logic [M:0]          rem;
  logic [W-1:0]        quot;

  assign gain_s   = (W+8)'($signed({1'b0, gain}));
  assign mag_full = prod_a[W+7] ? (W+8)'(-prod_a) : (W+8)'(prod_a);

  always_comb begin
    q0   = mk_c[M+W-1:M];
    rem  = {1'b0, mag_c} - (M+1)'(q0) * (M+1)'(PCT_DIVISOR);
    quot = (rem >= (M+1)'(PCT_DIVISOR)) ? q0 + W'(1) : q0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= (W+8)'(x) * gain_s;
      neg_b  <= prod_a[W+7];
      mag_b  <= mag_full[M-1:0];
      neg_c  <= neg_b;
      mag_c  <= mag_b;
      mk_c   <= (M+W)'(mag_b) * (M+W)'(RECIP);
      q      <= neg_c ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end
  end

endmodule

// File: rtl/core/ftm_merge.sv
// Merge stage: sums the lane results, applies master gain, boosts and saturates.
// Depends on ftm_pkg and ftm_pct_scale.
module ftm_merge import ftm_pkg::*; #(
  parameter int LANES = 4
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [GAIN_W-1:0]                     master_gain,
  input  logic [LANES-1:0][LANE_W-1:0]          lane_q,
  output logic signed [SAMPLE_W-1:0]            mix
);

  localparam int SW = LANE_W + $clog2(LANES);
  localparam int BW = SW + 5;

  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] sum;
  logic signed [SW:0]   mq;
  logic signed [BW-1:0] ext;
  logic signed [BW-1:0] boosted;
  logic signed [SAMPLE_W-1:0] sat;

  always_comb begin
    acc = '0;
    for (int i = 0; i < LANES; i++) begin
      acc = acc + SW'($signed(lane_q[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= acc;
    end
  end

  ftm_pct_scale #(.W(SW)) u_master (
    .clk  (clk),
    .en   (en),
    .x    (sum),
    .gain (master_gain),
    .q    (mq)
  );

  // times twelve as two shifted adds, then clamp to the sample range
  always_comb begin
    ext     = BW'(mq);
    boosted = (ext <<< 3) + (ext <<< 2);
    if (boosted > BW'(MIX_MAX)) begin
      sat = SAMPLE_W'(MIX_MAX);
    end else if (boosted < BW'(MIX_MIN)) begin
      sat = SAMPLE_W'(MIX_MIN);
    end else begin
      sat = boosted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mix <= sat;
    end
  end

endmodule

// File: rtl/core/ftm_meter.sv
// Windowed peak meter and output register of the mixer.
// Depends on ftm_pkg for the beat and result types.
module ftm_meter import ftm_pkg::*; #(
  parameter int WINDOW_LEN   = 120,
  parameter int LEVEL_STRIDE = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  mix_beat_t beat,
  output logic      out_vld,
  output result_t   res
);

  localparam int PW = (LEVEL_STRIDE > 1) ? $clog2(LEVEL_STRIDE) : 1;
  localparam int XW = $clog2(WINDOW_LEN + 1);

  logic [XW-1:0]       pos;
  logic [PW-1:0]       phase;
  logic [SAMPLE_W-1:0] peak;

  logic [XW-1:0]       pos_next;
  logic [PW-1:0]       phase_next;
  logic [SAMPLE_W-1:0] peak_next;
  logic [SAMPLE_W:0]   mag_ext;
  logic [SAMPLE_W-1:0] mag;
  logic                closed;

  always_comb begin
    mag_ext    = beat.mix[SAMPLE_W-1] ? -{1'b1, beat.mix} : {1'b0, beat.mix};
    mag        = mag_ext[SAMPLE_W-1:0];
    peak_next  = (phase == '0 && mag > peak) ? mag : peak;
    pos_next   = pos + XW'(1);
    phase_next = (phase == PW'(LEVEL_STRIDE - 1)) ? '0 : phase + PW'(1);
    closed     = (pos_next >= XW'(WINDOW_LEN)) || beat.loop_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      pos     <= '0;
      phase   <= '0;
      peak    <= '0;
    end else if (step) begin
      out_vld <= beat.vld;
      if (beat.vld) begin
        if (closed) begin
          pos   <= '0;
          phase <= '0;
          peak  <= '0;
        end else begin
          pos   <= pos_next;
          phase <= phase_next;
          peak  <= peak_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.mix_out     <= beat.mix;
      res.level_valid <= closed;
      res.level_peak  <= closed ? peak_next : '0;
    end
  end

endmodule
